>>> rtl/bcpt_pkg.sv
`timescale 1ns / 1ps

package bcpt_pkg;

   localparam int FrameRows = 60;
   localparam int FrameCols = 80;

   localparam logic [7:0] CONF_THRESHOLD = 8'hF0;
   localparam logic [7:0] WIN_TOL        = 8'h08;
   localparam logic [7:0] WIN_DEFAULT    = 8'h55;
   localparam logic [7:0] WIN_FULL       = 8'hFF;
   localparam logic [6:0] CENTER_COL     = 7'd40;
   localparam logic [6:0] CENTER_ROW     = 7'd30;
   localparam int         GAIN_SHIFT     = 3;
   localparam int         CMD_LIMIT      = 255;

   typedef enum logic {
      OP_PIXEL     = 1'b0,
      OP_FRAME_END = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      MODE_DARK_AUTO    = 3'd0,
      MODE_LIGHT_AUTO   = 3'd1,
      MODE_DARK_MANUAL  = 3'd2,
      MODE_LIGHT_MANUAL = 3'd3,
      MODE_TARGET       = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      CSR_FILTER_MODE   = 3'd0,
      CSR_MANUAL_VALUE  = 3'd1,
      CSR_GAIN_P_PAN    = 3'd2,
      CSR_GAIN_P_TILT   = 3'd3,
      CSR_GAIN_D_PAN    = 3'd4,
      CSR_GAIN_D_TILT   = 3'd5,
      CSR_DEADBAND_PAN  = 3'd6,
      CSR_DEADBAND_TILT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [2:0] filter_mode;
      logic [7:0] manual_value;
      logic [3:0] gain_p_pan;
      logic [3:0] gain_p_tilt;
      logic [3:0] gain_d_pan;
      logic [3:0] gain_d_tilt;
      logic [3:0] deadband_pan;
      logic [3:0] deadband_tilt;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      filter_mode:   3'd0,
      manual_value:  8'd0,
      gain_p_pan:    4'd2,
      gain_p_tilt:   4'd3,
      gain_d_pan:    4'd0,
      gain_d_tilt:   4'd1,
      deadband_pan:  4'd1,
      deadband_tilt: 4'd4
   };

   typedef struct packed {
      logic       seen;
      logic [6:0] min_row;
      logic [6:0] min_col;
      logic [6:0] max_row;
      logic [6:0] max_col;
   } box_type;

   typedef struct packed {
      logic [7:0] low;
      logic [7:0] high;
   } win_type;

   function automatic win_type derive_window(logic [2:0] mode, logic [7:0] value);
      win_type w;
      case (mode)
         MODE_DARK_AUTO: begin
            w.low  = 8'h00;
            w.high = WIN_DEFAULT;
         end
         MODE_LIGHT_AUTO: begin
            w.low  = WIN_DEFAULT;
            w.high = WIN_FULL;
         end
         MODE_DARK_MANUAL: begin
            w.low  = 8'h00;
            w.high = value;
         end
         MODE_LIGHT_MANUAL: begin
            w.low  = value;
            w.high = WIN_FULL;
         end
         default: begin
            w.low  = (value < WIN_TOL) ? value : value - WIN_TOL;
            w.high = (value > (WIN_FULL - WIN_TOL)) ? value : value + WIN_TOL;
         end
      endcase
      return w;
   endfunction

endpackage

>>> rtl/blob_centroid_pd_tracker_core.sv
// Bounding-box centroid tracker with PD pan/tilt output. Pixel words grow a
// box from every pixel whose confidence is above 0xF0 and that lies inside
// the 80 by 60 frame; a frame-end word closes the frame and returns one
// response word with the box center, the pan and tilt commands and the
// brightness window for the next frame, while pixel words return nothing.
// The block takes one word per clock while the input is not stalled: each
// word sits in an input register while its compares or its frame-end
// arithmetic (two small multiplies and an add per axis) run, and a frame-end
// result then goes to the response register once that register is free.
// Input stalls only while a finished response is not taken and a frame-end
// word is waiting behind it. Configuration writes take effect at once and
// must be made while no word is in flight.
`timescale 1ns / 1ps

module blob_centroid_pd_tracker_core (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_operation,
   input  logic [6:0]        req_pixel_row,
   input  logic [6:0]        req_pixel_col,
   input  logic [7:0]        req_confidence,
   input  logic [7:0]        req_frame_min_brightness,
   input  logic [7:0]        req_frame_max_brightness,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_target_found,
   output logic [6:0]        rsp_center_row,
   output logic [6:0]        rsp_center_col,
   output logic signed [8:0] rsp_pan_command,
   output logic signed [8:0] rsp_tilt_command,
   output logic [7:0]        rsp_window_low,
   output logic [7:0]        rsp_window_high,

   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_wdata
);

   bcpt_pkg::cfg_type cfg_ff;
   bcpt_pkg::cfg_type cfg_in;
   logic              win_reload;
   bcpt_pkg::win_type win_reload_value;

   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic       s1_op_ff;
   logic [6:0] s1_row_ff;
   logic [6:0] s1_col_ff;
   logic [7:0] s1_conf_ff;
   logic [7:0] s1_fmin_ff;
   logic [7:0] s1_fmax_ff;

   logic s1_go;
   logic pixel_go;
   logic frame_go;
   logic req_take;

   bcpt_pkg::box_type box;
   bcpt_pkg::win_type win_next;
   logic              adapt;

   logic [7:0]        row_sum;
   logic [7:0]        col_sum;
   logic [6:0]        center_row;
   logic [6:0]        center_col;
   logic signed [7:0] err_pan;
   logic signed [7:0] err_tilt;
   logic signed [8:0] pan_cmd;
   logic signed [8:0] tilt_cmd;

   logic signed [7:0] last_err_pan_ff;
   logic signed [7:0] last_err_tilt_ff;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_found_ff;
   logic [6:0]        rsp_row_ff;
   logic [6:0]        rsp_col_ff;
   logic signed [8:0] rsp_pan_ff;
   logic signed [8:0] rsp_tilt_ff;
   bcpt_pkg::win_type rsp_win_ff;

   // Configuration registers.
   always_comb begin
      cfg_in     = cfg_ff;
      win_reload = 1'b0;
      if (csr_we) begin
         unique case (bcpt_pkg::csr_index_type'(csr_index))
            bcpt_pkg::CSR_FILTER_MODE: begin
               cfg_in.filter_mode = csr_wdata[2:0];
               win_reload         = 1'b1;
            end
            bcpt_pkg::CSR_MANUAL_VALUE: begin
               cfg_in.manual_value = csr_wdata;
               win_reload          = 1'b1;
            end
            bcpt_pkg::CSR_GAIN_P_PAN:    cfg_in.gain_p_pan    = csr_wdata[3:0];
            bcpt_pkg::CSR_GAIN_P_TILT:   cfg_in.gain_p_tilt   = csr_wdata[3:0];
            bcpt_pkg::CSR_GAIN_D_PAN:    cfg_in.gain_d_pan    = csr_wdata[3:0];
            bcpt_pkg::CSR_GAIN_D_TILT:   cfg_in.gain_d_tilt   = csr_wdata[3:0];
            bcpt_pkg::CSR_DEADBAND_PAN:  cfg_in.deadband_pan  = csr_wdata[3:0];
            bcpt_pkg::CSR_DEADBAND_TILT: cfg_in.deadband_tilt = csr_wdata[3:0];
         endcase
      end
   end

   assign win_reload_value = bcpt_pkg::derive_window(cfg_in.filter_mode,
                                                     cfg_in.manual_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= bcpt_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register and flow control.
   assign s1_go    = s1_valid_ff
                  && ((s1_op_ff == bcpt_pkg::OP_PIXEL) || !rsp_valid_ff || rsp_ready);
   assign pixel_go = s1_go && (s1_op_ff == bcpt_pkg::OP_PIXEL);
   assign frame_go = s1_go && (s1_op_ff == bcpt_pkg::OP_FRAME_END);

   assign req_ready   = !s1_valid_ff || s1_go;
   assign req_take    = req_valid && req_ready;
   assign s1_valid_in = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= req_operation;
         s1_row_ff  <= req_pixel_row;
         s1_col_ff  <= req_pixel_col;
         s1_conf_ff <= req_confidence;
         s1_fmin_ff <= req_frame_min_brightness;
         s1_fmax_ff <= req_frame_max_brightness;
      end
   end

   bcpt_box u_box (
      .clock      (clock),
      .reset      (reset),
      .pixel_go   (pixel_go),
      .clear      (frame_go),
      .row        (s1_row_ff),
      .col        (s1_col_ff),
      .confidence (s1_conf_ff),
      .box        (box)
   );

   // Frame-end arithmetic.
   assign row_sum    = {1'b0, box.min_row} + {1'b0, box.max_row};
   assign col_sum    = {1'b0, box.min_col} + {1'b0, box.max_col};
   assign center_row = row_sum[7:1];
   assign center_col = col_sum[7:1];
   assign err_pan    = $signed({1'b0, bcpt_pkg::CENTER_COL}) - $signed({1'b0, center_col});
   assign err_tilt   = $signed({1'b0, bcpt_pkg::CENTER_ROW}) - $signed({1'b0, center_row});

   bcpt_pd u_pd_pan (
      .err    (err_pan),
      .prev   (last_err_pan_ff),
      .gain_p (cfg_ff.gain_p_pan),
      .gain_d (cfg_ff.gain_d_pan),
      .band   (cfg_ff.deadband_pan),
      .cmd    (pan_cmd)
   );

   bcpt_pd u_pd_tilt (
      .err    (err_tilt),
      .prev   (last_err_tilt_ff),
      .gain_p (cfg_ff.gain_p_tilt),
      .gain_d (cfg_ff.gain_d_tilt),
      .band   (cfg_ff.deadband_tilt),
      .cmd    (tilt_cmd)
   );

   assign adapt = frame_go && box.seen;

   bcpt_window u_window (
      .clock        (clock),
      .reset        (reset),
      .reload       (win_reload),
      .reload_value (win_reload_value),
      .adapt        (adapt),
      .filter_mode  (cfg_ff.filter_mode),
      .frame_min    (s1_fmin_ff),
      .frame_max    (s1_fmax_ff),
      .win_next     (win_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_pan_ff  <= 8'sd0;
         last_err_tilt_ff <= 8'sd0;
      end else if (adapt) begin
         last_err_pan_ff  <= err_pan;
         last_err_tilt_ff <= err_tilt;
      end
   end

   // Response register.
   assign rsp_valid_in = frame_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_go) begin
         rsp_found_ff <= box.seen;
         rsp_row_ff   <= box.seen ? center_row : 7'd0;
         rsp_col_ff   <= box.seen ? center_col : 7'd0;
         rsp_pan_ff   <= box.seen ? pan_cmd : 9'sd0;
         rsp_tilt_ff  <= box.seen ? tilt_cmd : 9'sd0;
         rsp_win_ff   <= win_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target_found = rsp_found_ff;
   assign rsp_center_row   = rsp_row_ff;
   assign rsp_center_col   = rsp_col_ff;
   assign rsp_pan_command  = rsp_pan_ff;
   assign rsp_tilt_command = rsp_tilt_ff;
   assign rsp_window_low   = rsp_win_ff.low;
   assign rsp_window_high  = rsp_win_ff.high;

endmodule

>>> rtl/bcpt_box.sv
`timescale 1ns / 1ps

module bcpt_box (
   input  logic                clock,
   input  logic                reset,
   input  logic                pixel_go,
   input  logic                clear,
   input  logic [6:0]          row,
   input  logic [6:0]          col,
   input  logic [7:0]          confidence,
   output bcpt_pkg::box_type   box
);

   localparam logic [6:0] ROWS_RESET = 7'(bcpt_pkg::FrameRows);
   localparam logic [6:0] COLS_RESET = 7'(bcpt_pkg::FrameCols);

   bcpt_pkg::box_type box_ff;
   bcpt_pkg::box_type box_in;
   logic              hit;

   assign hit = (confidence > bcpt_pkg::CONF_THRESHOLD)
             && ({1'b0, row} < 8'(bcpt_pkg::FrameRows))
             && ({1'b0, col} < 8'(bcpt_pkg::FrameCols));

   always_comb begin
      box_in = box_ff;
      if (clear) begin
         box_in.seen    = 1'b0;
         box_in.min_row = ROWS_RESET;
         box_in.min_col = COLS_RESET;
         box_in.max_row = 7'd0;
         box_in.max_col = 7'd0;
      end else if (pixel_go && hit) begin
         box_in.seen = 1'b1;
         if (row < box_ff.min_row) box_in.min_row = row;
         if (col < box_ff.min_col) box_in.min_col = col;
         if (row > box_ff.max_row) box_in.max_row = row;
         if (col > box_ff.max_col) box_in.max_col = col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff.seen    <= 1'b0;
         box_ff.min_row <= ROWS_RESET;
         box_ff.min_col <= COLS_RESET;
         box_ff.max_row <= 7'd0;
         box_ff.max_col <= 7'd0;
      end else begin
         box_ff <= box_in;
      end
   end

   assign box = box_ff;

endmodule

>>> rtl/bcpt_pd.sv
`timescale 1ns / 1ps

module bcpt_pd (
   input  logic signed [7:0] err,
   input  logic signed [7:0] prev,
   input  logic        [3:0] gain_p,
   input  logic        [3:0] gain_d,
   input  logic        [3:0] band,
   output logic signed [8:0] cmd
);

   logic signed [8:0]  diff;
   logic signed [13:0] prod_p;
   logic signed [13:0] prod_d;
   logic signed [13:0] sum;
   logic signed [13:0] sum_adj;
   logic signed [10:0] quot;
   logic signed [10:0] band_s;
   logic signed [10:0] limit_s;

   assign diff    = 9'(err) - 9'(prev);
   assign prod_p  = 14'(err) * 14'($signed({1'b0, gain_p}));
   assign prod_d  = 14'(diff) * 14'($signed({1'b0, gain_d}));
   assign sum     = prod_p + prod_d;
   // Bias negative sums so the arithmetic shift truncates toward zero.
   assign sum_adj = sum[13] ? sum + 14'sd7 : sum;
   assign quot    = 11'(sum_adj >>> bcpt_pkg::GAIN_SHIFT);
   assign band_s  = $signed({7'd0, band});
   assign limit_s = 11'(bcpt_pkg::CMD_LIMIT);

   always_comb begin
      if ((quot < band_s) && (quot > -band_s)) begin
         cmd = 9'sd0;
      end else if (quot > limit_s) begin
         cmd = 9'(limit_s);
      end else if (quot < -limit_s) begin
         cmd = 9'(-limit_s);
      end else begin
         cmd = 9'(quot);
      end
   end

endmodule

>>> rtl/bcpt_window.sv
`timescale 1ns / 1ps

module bcpt_window (
   input  logic                clock,
   input  logic                reset,
   input  logic                reload,
   input  bcpt_pkg::win_type   reload_value,
   input  logic                adapt,
   input  logic [2:0]          filter_mode,
   input  logic [7:0]          frame_min,
   input  logic [7:0]          frame_max,
   output bcpt_pkg::win_type   win_next
);

   bcpt_pkg::win_type win_ff;
   bcpt_pkg::win_type win_in;
   bcpt_pkg::win_type adapted;

   always_comb begin
      adapted = win_ff;
      if (filter_mode == bcpt_pkg::MODE_DARK_AUTO) begin
         adapted.high = (frame_min > (bcpt_pkg::WIN_FULL - bcpt_pkg::WIN_TOL))
                      ? frame_min : frame_min + bcpt_pkg::WIN_TOL;
      end else if (filter_mode == bcpt_pkg::MODE_LIGHT_AUTO) begin
         adapted.low = (frame_max < bcpt_pkg::WIN_TOL)
                     ? frame_max : frame_max - bcpt_pkg::WIN_TOL;
      end
   end

   assign win_next = adapt ? adapted : win_ff;

   always_comb begin
      win_in = win_next;
      if (reload) begin
         win_in = reload_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= bcpt_pkg::derive_window(bcpt_pkg::CFG_RESET.filter_mode,
                                           bcpt_pkg::CFG_RESET.manual_value);
      end else begin
         win_ff <= win_in;
      end
   end

endmodule

>>> rtl/bcpt_checker.sv
`timescale 1ns / 1ps

module bcpt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_target_found,
   input logic [6:0]        rsp_center_row,
   input logic [6:0]        rsp_center_col,
   input logic signed [8:0] rsp_pan_command,
   input logic signed [8:0] rsp_tilt_command,
   input logic [7:0]        rsp_window_low,
   input logic [7:0]        rsp_window_high
);

   // A response word that is not taken holds its found flag, commands and window.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable(rsp_target_found) && $stable(rsp_pan_command)
         && $stable(rsp_tilt_command) && $stable(rsp_window_low)
         && $stable(rsp_window_high))
      else $error("response word changed while stalled");

   // Reset leaves no response pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // With the response side empty, the input side is never stalled.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty response register");

   // An empty frame reports no center and no motion.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_target_found |-> rsp_center_row == 7'd0
         && rsp_center_col == 7'd0 && rsp_pan_command == 9'sd0
         && rsp_tilt_command == 9'sd0)
      else $error("empty frame reported a target");

   // The brightness window never inverts.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_window_low <= rsp_window_high)
      else $error("brightness window inverted");

endmodule

bind blob_centroid_pd_tracker_core bcpt_checker u_checker (.*);

>>> dv/tracker_checker.sv
`timescale 1ns / 1ps

module tracker_checker
   import bcpt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_operation,
   input  logic [6:0]        req_pixel_row,
   input  logic [6:0]        req_pixel_col,
   input  logic [7:0]        req_confidence,
   input  logic [7:0]        req_frame_min_brightness,
   input  logic [7:0]        req_frame_max_brightness,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_target_found,
   input  logic [6:0]        rsp_center_row,
   input  logic [6:0]        rsp_center_col,
   input  logic signed [8:0] rsp_pan_command,
   input  logic signed [8:0] rsp_tilt_command,
   input  logic [7:0]        rsp_window_low,
   input  logic [7:0]        rsp_window_high,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   output int                mismatch_count,
   output int                reports_due
);

   typedef struct {
      logic              found;
      logic [6:0]        row;
      logic [6:0]        col;
      logic signed [8:0] pan;
      logic signed [8:0] tilt;
      logic [7:0]        low;
      logic [7:0]        high;
   } track_report_t;

   track_report_t due_q[$];

   logic [2:0] mode;
   logic [7:0] mval;
   logic [3:0] kp_pan, kp_tilt, kd_pan, kd_tilt, db_pan, db_tilt;
   int         box_top, box_left, box_bottom, box_right;
   logic       box_hit;
   int         prev_err_pan, prev_err_tilt;
   logic [7:0] win_low, win_high;

   function void rederive_window();
      case (mode)
         MODE_DARK_AUTO: begin
            win_low  = 8'h00;
            win_high = WIN_DEFAULT;
         end
         MODE_LIGHT_AUTO: begin
            win_low  = WIN_DEFAULT;
            win_high = WIN_FULL;
         end
         MODE_DARK_MANUAL: begin
            win_low  = 8'h00;
            win_high = mval;
         end
         MODE_LIGHT_MANUAL: begin
            win_low  = mval;
            win_high = WIN_FULL;
         end
         default: begin
            win_low  = (mval < WIN_TOL) ? mval : mval - WIN_TOL;
            win_high = (mval > WIN_FULL - WIN_TOL) ? mval : mval + WIN_TOL;
         end
      endcase
   endfunction

   function void clear_box();
      box_top    = FrameRows;
      box_left   = FrameCols;
      box_bottom = 0;
      box_right  = 0;
      box_hit    = 1'b0;
   endfunction

   function automatic int pd_step(int err, int prev, int kp, int kd, int band);
      int c;
      c = (err * kp + (err - prev) * kd) / (1 << GAIN_SHIFT);
      if (c < band && c > -band) begin
         c = 0;
      end
      if (c > CMD_LIMIT) begin
         c = CMD_LIMIT;
      end
      if (c < -CMD_LIMIT) begin
         c = -CMD_LIMIT;
      end
      return c;
   endfunction

   function void take_pixel(int row, int col, logic [7:0] conf);
      if (conf > CONF_THRESHOLD && row < FrameRows && col < FrameCols) begin
         if (row < box_top) box_top = row;
         if (col < box_left) box_left = col;
         if (row > box_bottom) box_bottom = row;
         if (col > box_right) box_right = col;
         box_hit = 1'b1;
      end
   endfunction

   function void close_frame(logic [7:0] fmin, logic [7:0] fmax);
      track_report_t r;
      int            err_pan, err_tilt;
      r.found = box_hit;
      r.row   = '0;
      r.col   = '0;
      r.pan   = '0;
      r.tilt  = '0;
      if (box_hit) begin
         r.row    = 7'((box_top + box_bottom) / 2);
         r.col    = 7'((box_left + box_right) / 2);
         err_pan  = int'(CENTER_COL) - int'(r.col);
         err_tilt = int'(CENTER_ROW) - int'(r.row);
         r.pan    = 9'(pd_step(err_pan, prev_err_pan, kp_pan, kd_pan, db_pan));
         r.tilt   = 9'(pd_step(err_tilt, prev_err_tilt, kp_tilt, kd_tilt, db_tilt));
         prev_err_pan  = err_pan;
         prev_err_tilt = err_tilt;
         if (mode == MODE_DARK_AUTO) begin
            win_high = (fmin > WIN_FULL - WIN_TOL) ? fmin : fmin + WIN_TOL;
         end else if (mode == MODE_LIGHT_AUTO) begin
            win_low = (fmax < WIN_TOL) ? fmax : fmax - WIN_TOL;
         end
      end
      clear_box();
      r.low  = win_low;
      r.high = win_high;
      due_q.push_back(r);
   endfunction

   function void check_field(string name, logic signed [9:0] exp_v, logic signed [9:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      track_report_t e;
      if (reset) begin
         mode    = CFG_RESET.filter_mode;
         mval    = CFG_RESET.manual_value;
         kp_pan  = CFG_RESET.gain_p_pan;
         kp_tilt = CFG_RESET.gain_p_tilt;
         kd_pan  = CFG_RESET.gain_d_pan;
         kd_tilt = CFG_RESET.gain_d_tilt;
         db_pan  = CFG_RESET.deadband_pan;
         db_tilt = CFG_RESET.deadband_tilt;
         prev_err_pan  = 0;
         prev_err_tilt = 0;
         clear_box();
         rederive_window();
         due_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_FILTER_MODE: begin
                  mode = csr_wdata[2:0];
                  rederive_window();
               end
               CSR_MANUAL_VALUE: begin
                  mval = csr_wdata;
                  rederive_window();
               end
               CSR_GAIN_P_PAN:    kp_pan  = csr_wdata[3:0];
               CSR_GAIN_P_TILT:   kp_tilt = csr_wdata[3:0];
               CSR_GAIN_D_PAN:    kd_pan  = csr_wdata[3:0];
               CSR_GAIN_D_TILT:   kd_tilt = csr_wdata[3:0];
               CSR_DEADBAND_PAN:  db_pan  = csr_wdata[3:0];
               CSR_DEADBAND_TILT: db_tilt = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (due_q.size() == 0) begin
               $error("response word with no frame end waiting for it");
               mismatch_count++;
            end else begin
               e = due_q.pop_front();
               check_field("target_found", 10'(e.found), 10'(rsp_target_found));
               check_field("center_row", 10'(e.row), 10'(rsp_center_row));
               check_field("center_col", 10'(e.col), 10'(rsp_center_col));
               check_field("pan_command", 10'(e.pan), 10'(rsp_pan_command));
               check_field("tilt_command", 10'(e.tilt), 10'(rsp_tilt_command));
               check_field("window_low", 10'(e.low), 10'(rsp_window_low));
               check_field("window_high", 10'(e.high), 10'(rsp_window_high));
            end
         end
         if (req_valid && req_ready) begin
            if (req_operation == OP_PIXEL) begin
               take_pixel(int'(req_pixel_row), int'(req_pixel_col), req_confidence);
            end else begin
               close_frame(req_frame_min_brightness, req_frame_max_brightness);
            end
         end
      end
      reports_due <= due_q.size();
   end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import bcpt_pkg::*;

   localparam logic [2:0] MODE_SPARE_LAST = 3'd7;

   typedef struct {
      op_type     op;
      logic [6:0] row;
      logic [6:0] col;
      logic [7:0] conf;
      logic [7:0] fmin;
      logic [7:0] fmax;
   } cam_word_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_operation = OP_PIXEL;
   logic [6:0]        req_pixel_row = '0;
   logic [6:0]        req_pixel_col = '0;
   logic [7:0]        req_confidence = '0;
   logic [7:0]        req_frame_min_brightness = '0;
   logic [7:0]        req_frame_max_brightness = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_target_found;
   logic [6:0]        rsp_center_row;
   logic [6:0]        rsp_center_col;
   logic signed [8:0] rsp_pan_command;
   logic signed [8:0] rsp_tilt_command;
   logic [7:0]        rsp_window_low;
   logic [7:0]        rsp_window_high;
   logic              csr_we = 1'b0;
   logic [2:0]        csr_index = CSR_FILTER_MODE;
   logic [7:0]        csr_wdata = '0;

   int mismatch_count;
   int reports_due;
   int words_sent = 0;
   int send_idle_pct = 31;
   int recv_idle_pct = 81;

   blob_centroid_pd_tracker_core DUT (.*);

   tracker_checker u_checker (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic put_word(input cam_word_t w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid                <= 1'b1;
      req_operation            <= w.op;
      req_pixel_row            <= w.row;
      req_pixel_col            <= w.col;
      req_confidence           <= w.conf;
      req_frame_min_brightness <= w.fmin;
      req_frame_max_brightness <= w.fmax;
      do @(posedge clock); while (req_ready !== 1'b1);
      words_sent++;
   endtask

   task automatic put_pixel(input logic [6:0] row, input logic [6:0] col,
                            input logic [7:0] conf);
      cam_word_t w;
      w.op   = OP_PIXEL;
      w.row  = row;
      w.col  = col;
      w.conf = conf;
      w.fmin = 8'($urandom);
      w.fmax = 8'($urandom);
      put_word(w);
   endtask

   task automatic put_frame_end(input logic [7:0] fmin, input logic [7:0] fmax);
      cam_word_t w;
      w.op   = OP_FRAME_END;
      w.row  = 7'($urandom);
      w.col  = 7'($urandom);
      w.conf = 8'($urandom);
      w.fmin = fmin;
      w.fmax = fmax;
      put_word(w);
   endtask

   // Pixel words give no response, so the extra cycles cover one still in flight.
   task automatic wait_drained(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_due != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [2:0] mode, input logic [7:0] mval,
                                input logic [3:0] kpp, input logic [3:0] kpt,
                                input logic [3:0] kdp, input logic [3:0] kdt,
                                input logic [3:0] dbp, input logic [3:0] dbt);
      wait_drained(4);
      write_reg(CSR_FILTER_MODE, 8'(mode));
      write_reg(CSR_MANUAL_VALUE, mval);
      write_reg(CSR_GAIN_P_PAN, 8'(kpp));
      write_reg(CSR_GAIN_P_TILT, 8'(kpt));
      write_reg(CSR_GAIN_D_PAN, 8'(kdp));
      write_reg(CSR_GAIN_D_TILT, 8'(kdt));
      write_reg(CSR_DEADBAND_PAN, 8'(dbp));
      write_reg(CSR_DEADBAND_TILT, 8'(dbt));
      csr_we <= 1'b0;
   endtask

   function automatic logic [3:0] pick_gain();
      case ($urandom_range(0, 3))
         0:       return 4'h0;
         1:       return 4'hF;
         default: return 4'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'h07;
         2:       return 8'h08;
         3:       return 8'hF7;
         4:       return 8'hF8;
         5:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic random_settings();
      load_settings(3'($urandom), pick_level(), pick_gain(), pick_gain(),
                    pick_gain(), pick_gain(), pick_gain(), pick_gain());
   endtask

   task automatic random_frame();
      int         count;
      logic [6:0] row, col;
      logic [7:0] conf;
      count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
      repeat (count) begin
         if ($urandom_range(0, 9) < 7) begin
            row = 7'($urandom_range(0, FrameRows - 1));
            col = 7'($urandom_range(0, FrameCols - 1));
         end else begin
            row = 7'($urandom);
            col = 7'($urandom);
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: conf = 8'($urandom_range(int'(CONF_THRESHOLD) + 1, 255));
            6:                conf = CONF_THRESHOLD;
            default:          conf = 8'($urandom);
         endcase
         put_pixel(row, col, conf);
      end
      put_frame_end(pick_level(), pick_level());
   endtask

   initial begin
      int target;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: an empty frame, then pixels that must not count, then two that do.
      put_frame_end(8'h00, 8'hFF);
      put_pixel(7'd0, 7'd0, CONF_THRESHOLD);
      put_pixel(7'(FrameRows), 7'd0, 8'hFF);
      put_pixel(7'd0, 7'(FrameCols), 8'hFF);
      put_pixel(7'h7F, 7'h7F, 8'hFF);
      put_frame_end(8'hF8, 8'h00);
      put_pixel(7'd0, 7'd0, 8'hF1);
      put_pixel(7'(FrameRows - 1), 7'(FrameCols - 1), 8'hFF);
      put_frame_end(8'hF8, 8'h07);

      load_settings(MODE_LIGHT_AUTO, 8'h00, 4'hF, 4'hF, 4'hF, 4'hF, 4'h0, 4'h0);
      put_pixel(7'd0, 7'd0, 8'hFF);
      put_frame_end(8'h00, 8'h07);
      put_pixel(7'(FrameRows - 1), 7'(FrameCols - 1), 8'hFF);
      put_frame_end(8'h00, 8'h08);

      load_settings(MODE_TARGET, 8'h03, 4'h0, 4'h0, 4'h0, 4'h0, 4'hF, 4'hF);
      put_pixel(7'(CENTER_ROW), 7'(CENTER_COL), 8'hFF);
      put_frame_end(8'h00, 8'hFF);

      load_settings(MODE_SPARE_LAST, 8'hFF, 4'h1, 4'h1, 4'hF, 4'hF, 4'hF, 4'hF);
      put_pixel(7'd5, 7'd70, 8'hF5);
      put_pixel(7'h7F, 7'd0, 8'hFF);
      put_frame_end(8'h55, 8'hAA);

      load_settings(MODE_DARK_MANUAL, 8'hFF, 4'h7, 4'h9, 4'h3, 4'h5, 4'h2, 4'h3);
      put_frame_end(8'hFF, 8'hFF);

      load_settings(MODE_LIGHT_MANUAL, 8'h00, 4'h7, 4'h9, 4'h3, 4'h5, 4'h2, 4'h3);
      put_pixel(7'd10, 7'd60, 8'hFE);
      put_frame_end(8'h10, 8'hF0);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 31;
               recv_idle_pct = 81;
            end
            1: begin
               send_idle_pct = 81;
               recv_idle_pct = 31;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int seg = 0; seg < 4; seg++) begin
            random_settings();
            target = words_sent + 58;
            while (words_sent < target) random_frame();
         end
      end

      wait_drained(10);
      if (mismatch_count == 0 && reports_due == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> sim.f
rtl/bcpt_pkg.sv
rtl/bcpt_box.sv
rtl/bcpt_pd.sv
rtl/bcpt_window.sv
rtl/blob_centroid_pd_tracker_core.sv
rtl/bcpt_checker.sv
dv/tracker_checker.sv
dv/tb_top.sv
